### sv/assert_macros.svh
// assertion helpers, sampled on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define KT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define KT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### sv/ktpc_pkg.sv
package ktpc_pkg;

  localparam int unsigned MAX_SAMPLES_DEF  = 1024;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_OUT_W = 19;
  localparam int unsigned TOTAL_W   = 11;
  localparam int unsigned TAU_W     = 32;
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned QUO_W     = FRAC_BITS + 1;

  typedef struct packed {
    logic load;
    logic close;
    logic walk_step;
    logic div_start;
    logic out_load;
  } ktpc_cmd_t;

  typedef struct packed {
    logic has_sample;
    logic walk_last;
    logic div_done;
    logic out_busy;
  } ktpc_status_t;

endpackage

### sv/kendall_tau_pair_counter.sv
// after the closing transaction the pair walk covers every pair i < j through the single
// compare unit on the two-read-port sample memory; then drain and setup, the bit-serial
// divider and the output load follow in that order
// throughput: one sample per cycle while loading; one result per set
// reset: control, counts and flags clear at once; the sample memory and the registered result outputs are not cleared
module kendall_tau_pair_counter import ktpc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES  = MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] x_value_i,
  input  logic signed [DATA_W-1:0] y_value_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CNT_OUT_W-1:0]     concordant_count_o,
  output logic [CNT_OUT_W-1:0]     discordant_count_o,
  output logic signed [TAU_W-1:0]  tau_q30_o,
  output logic [TOTAL_W-1:0]       sample_total_o,
  output logic                     result_valid_o,
  output logic                     overflowed_o
);

  ktpc_cmd_t    cmd;
  ktpc_status_t status;

  ktpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ktpc_dpath #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .x_value_i          (x_value_i),
    .y_value_i          (y_value_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .concordant_count_o (concordant_count_o),
    .discordant_count_o (discordant_count_o),
    .tau_q30_o          (tau_q30_o),
    .sample_total_o     (sample_total_o),
    .result_valid_o     (result_valid_o),
    .overflowed_o       (overflowed_o)
  );

endmodule

### sv/ktpc_div.sv
`include "assert_macros.svh"

module ktpc_div import ktpc_pkg::*; #(
  parameter int unsigned PW = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [PW-1:0]    dividend_i,
  input  logic [PW-1:0]    divisor_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quot_o
);

  localparam int unsigned SW = $clog2(QUO_W);

  logic             busy_q, busy_d;
  logic [SW-1:0]    step_q, step_d;
  logic [PW:0]      rem_q, rem_d;
  logic [PW-1:0]    dvs_q, dvs_d;
  logic [QUO_W-1:0] quot_q, quot_d;
  logic             ge;
  logic [PW:0]      rem_sub;

  // restoring division, one quotient bit per cycle
  assign ge      = rem_q >= {1'b0, dvs_q};
  assign rem_sub = ge ? (rem_q - {1'b0, dvs_q}) : rem_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = SW'(QUO_W - 1);
      rem_d  = {1'b0, dividend_i};
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = {rem_sub[PW-1:0], 1'b0};
      quot_d = {quot_q[QUO_W-2:0], ge};
      step_d = step_q - SW'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = busy_q && (step_q == '0);
  assign quot_o = quot_q;

  `KT_ASSERT(a_quot_range, $fell(busy_q) |-> (quot_q <= {1'b1, {(QUO_W-1){1'b0}}}), "quotient above one")
  `KT_ASSERT_NEVER(a_start_busy, start_i && busy_q, "divider restarted while busy")

endmodule

### sv/ktpc_dpath.sv
`include "assert_macros.svh"

module ktpc_dpath import ktpc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES  = MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ktpc_cmd_t                  cmd_i,
  output ktpc_status_t               status_o,
  input  logic signed [DATA_W-1:0]   x_value_i,
  input  logic signed [DATA_W-1:0]   y_value_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [CNT_OUT_W-1:0]       concordant_count_o,
  output logic [CNT_OUT_W-1:0]       discordant_count_o,
  output logic signed [TAU_W-1:0]    tau_q30_o,
  output logic [TOTAL_W-1:0]         sample_total_o,
  output logic                       result_valid_o,
  output logic                       overflowed_o
);

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned PW = 2 * NW;
  localparam int unsigned EW = 2 * SAMPLE_WIDTH;

  logic [SAMPLE_WIDTH-1:0] xs, ys;
  logic [EW-1:0]           mem [MAX_SAMPLES];
  logic [EW-1:0]           rd_a_q, rd_b_q;
  logic                    rd_vld_q;

  logic [NW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          res_valid_q, res_valid_d;
  logic          full;
  logic [AW-1:0] i_q, i_d, j_q, j_d;
  logic          j_end;

  logic [PW-1:0] conc_q, conc_d, disc_q, disc_d;
  logic [PW-1:0] prod, pairs_q;
  logic          neg_q, neg_d;
  logic [PW-1:0] mag;

  logic signed [SAMPLE_WIDTH-1:0] xa, xb, ya, yb;
  logic          conc_hit, disc_hit;

  logic             div_done;
  logic [QUO_W-1:0] quot;
  logic [TAU_W-1:0] tau_mag, tau_val;
  logic             out_valid_q, out_valid_d;

  if (SAMPLE_WIDTH <= DATA_W) begin : g_narrow
    assign xs = x_value_i[SAMPLE_WIDTH-1:0];
    assign ys = y_value_i[SAMPLE_WIDTH-1:0];
  end else begin : g_wide
    assign xs = {{(SAMPLE_WIDTH-DATA_W){x_value_i[DATA_W-1]}}, x_value_i};
    assign ys = {{(SAMPLE_WIDTH-DATA_W){y_value_i[DATA_W-1]}}, y_value_i};
  end

  assign full = count_q == NW'(MAX_SAMPLES);

  // sample store, one write and two read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem[count_q[AW-1:0]] <= {xs, ys};
    end
    rd_a_q <= mem[i_q];
    rd_b_q <= mem[j_q];
  end

  assign xa = rd_a_q[EW-1:SAMPLE_WIDTH];
  assign ya = rd_a_q[SAMPLE_WIDTH-1:0];
  assign xb = rd_b_q[EW-1:SAMPLE_WIDTH];
  assign yb = rd_b_q[SAMPLE_WIDTH-1:0];

  assign conc_hit = ((xa < xb) && (ya < yb)) || ((xa > xb) && (ya > yb));
  assign disc_hit = ((xa < xb) && (ya > yb)) || ((xa > xb) && (ya < yb));

  // pair index walk over i < j
  assign j_end = (NW'(j_q) + NW'(1)) == count_q;

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (cmd_i.close) begin
      i_d = '0;
      j_d = AW'(1);
    end else if (cmd_i.walk_step) begin
      if (j_end) begin
        i_d = i_q + AW'(1);
        j_d = i_q + AW'(2);
      end else begin
        j_d = j_q + AW'(1);
      end
    end
  end

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    res_valid_d = res_valid_q;
    conc_d      = conc_q;
    disc_d      = disc_q;
    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + NW'(1);
      end
    end
    if (cmd_i.close) begin
      res_valid_d = count_q != '0;
    end
    if (rd_vld_q) begin
      conc_d = conc_q + PW'(conc_hit);
      disc_d = disc_q + PW'(disc_hit);
    end
    if (cmd_i.out_load) begin
      count_d     = '0;
      ovf_d       = 1'b0;
      res_valid_d = 1'b0;
      conc_d      = '0;
      disc_d      = '0;
    end
  end

  assign prod  = PW'(count_q) * PW'(count_q - NW'(1));
  assign mag   = (disc_q > conc_q) ? (disc_q - conc_q) : (conc_q - disc_q);
  assign neg_d = cmd_i.div_start ? (disc_q > conc_q) : neg_q;

  ktpc_div #(
    .PW (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag),
    .divisor_i  (pairs_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign tau_mag = TAU_W'(quot);
  assign tau_val = neg_q ? (~tau_mag + TAU_W'(1)) : tau_mag;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      conc_q      <= '0;
      disc_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
      conc_q      <= conc_d;
      disc_q      <= disc_d;
      rd_vld_q    <= cmd_i.walk_step;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pairs_q <= prod >> 1;
    neg_q   <= neg_d;
    if (cmd_i.out_load) begin
      concordant_count_o <= CNT_OUT_W'(conc_q);
      discordant_count_o <= CNT_OUT_W'(disc_q);
      tau_q30_o          <= res_valid_q ? tau_val : '0;
      sample_total_o     <= TOTAL_W'(count_q);
      result_valid_o     <= res_valid_q;
      overflowed_o       <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.has_sample = count_q != '0;
  assign status_o.walk_last  = j_end && ((NW'(i_q) + NW'(2)) == count_q);
  assign status_o.div_done   = div_done;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  `KT_ASSERT(a_ovf_full, ovf_q |-> full, "overflow flagged below capacity")
  `KT_ASSERT(a_pair_sum, (cmd_i.out_load && res_valid_q) |-> (({1'b0, conc_q} + {1'b0, disc_q}) <= {1'b0, pairs_q}), "more counted pairs than exist")
  `KT_ASSERT_NEVER(a_div_early, rd_vld_q && cmd_i.div_start, "divide started before counts settled")

endmodule

### sv/ktpc_ctrl.sv
`include "assert_macros.svh"

module ktpc_ctrl import ktpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         last_i,
  output logic         in_ready_o,
  input  ktpc_status_t status_i,
  output ktpc_cmd_t    cmd_o
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = state_q == S_LOAD;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            cmd_o.close = 1'b1;
            // a set whose closing sample is its only one skips the walk
            state_d = status_i.has_sample ? S_WALK : S_OUT;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.walk_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  `KT_ASSERT(a_div_after_walk, cmd_o.div_start |-> ($past(state_q) == S_DRAIN), "divide not preceded by drain")

endmodule
